[src/hsv2a_pkg.sv]
package hsv2a_pkg;

   // Fixed point: 1024 stands for 1.0 on saturation and brightness
   localparam int FX_ONE      = 1024;
   localparam int FX_BITS     = 10;
   localparam int UNIT_W      = FX_BITS + 1;

   // Hue: 1/16 degree units, 960 per 60-degree sector, 5760 per turn
   localparam int HUE_W       = 16;
   localparam int HUE_SECTOR  = 960;
   localparam int HUE_EXT_W   = HUE_W + 1;
   // Six full turns lift every signed hue into a positive range
   localparam logic [HUE_EXT_W-1:0] HUE_LIFT = HUE_EXT_W'(6 * 5760);
   localparam int SECT_IDX_W  = 7;
   localparam int HUE_FRAC_W  = 10;

   // Reciprocal of 15 for dividing by 960 after a shift by 6
   localparam int RECIP15       = 34953;
   localparam int RECIP15_SHIFT = 19;
   // Reciprocal of 6 for narrow sector indexes
   localparam int RECIP6        = 43;
   localparam int RECIP6_SHIFT  = 8;

   // Sectors of the colour wheel
   localparam logic [2:0] SECT_RED_YELLOW     = 3'd0;
   localparam logic [2:0] SECT_YELLOW_GREEN   = 3'd1;
   localparam logic [2:0] SECT_GREEN_CYAN     = 3'd2;
   localparam logic [2:0] SECT_CYAN_BLUE      = 3'd3;
   localparam logic [2:0] SECT_BLUE_MAGENTA   = 3'd4;
   localparam logic [2:0] SECT_MAGENTA_RED    = 3'd5;

   // Load enables for the two hue stages
   typedef struct packed {
      logic s1;
      logic s2;
   } hue_en_type;

endpackage

[src/hsv2a_hue_split.sv]
// Two-stage hue reduction: sector number and distance into the sector.
module hsv2a_hue_split (
   input  logic                                   clock,
   input  hsv2a_pkg::hue_en_type                  en,
   input  logic signed [hsv2a_pkg::HUE_W-1:0]     hue,
   output logic [2:0]                             sector,
   output logic [hsv2a_pkg::HUE_FRAC_W-1:0]       span
);

   logic [hsv2a_pkg::HUE_EXT_W-1:0]  hh_in, hh_ff;
   logic [hsv2a_pkg::SECT_IDX_W-1:0] idx_in, idx_ff;
   logic [27:0]                      idx_prod;
   logic [11:0]                      six_prod;
   logic [hsv2a_pkg::HUE_EXT_W-1:0]  frac_full;
   logic [hsv2a_pkg::SECT_IDX_W-1:0] sect_full;
   logic [hsv2a_pkg::HUE_FRAC_W-1:0] frac;
   logic [2:0]                       sector_in, sector_ff;
   logic [hsv2a_pkg::HUE_FRAC_W-1:0] span_in, span_ff;

   // Stage 1: lift into positive range, index of 60-degree step
   always_comb begin
      hh_in    = hsv2a_pkg::HUE_EXT_W'({hue[hsv2a_pkg::HUE_W-1], hue}) + hsv2a_pkg::HUE_LIFT;
      idx_prod = 28'(hh_in >> 6) * 28'(hsv2a_pkg::RECIP15);
      idx_in   = hsv2a_pkg::SECT_IDX_W'(idx_prod >> hsv2a_pkg::RECIP15_SHIFT);
   end

   // Stage 2: sector modulo six, fold distance in odd sectors
   always_comb begin
      frac_full = hh_ff - hsv2a_pkg::HUE_EXT_W'(idx_ff)
                  * hsv2a_pkg::HUE_EXT_W'(hsv2a_pkg::HUE_SECTOR);
      frac      = frac_full[hsv2a_pkg::HUE_FRAC_W-1:0];
      six_prod  = 12'(idx_ff) * 12'(hsv2a_pkg::RECIP6);
      sect_full = idx_ff - hsv2a_pkg::SECT_IDX_W'(six_prod >> hsv2a_pkg::RECIP6_SHIFT)
                  * hsv2a_pkg::SECT_IDX_W'(6);
      sector_in = sect_full[2:0];
      if (sector_in[0]) begin
         span_in = hsv2a_pkg::HUE_FRAC_W'(hsv2a_pkg::HUE_SECTOR) - frac;
      end else begin
         span_in = frac;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         hh_ff  <= hh_in;
         idx_ff <= idx_in;
      end
      if (en.s2) begin
         sector_ff <= sector_in;
         span_ff   <= span_in;
      end
   end

   assign sector = sector_ff;
   assign span   = span_ff;

endmodule

[src/hsv_to_argb_pixel.sv]
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// request   | req_valid, req_stall, req_hue,               | in
//           | req_saturation, req_brightness               |
// response  | rsp_valid, rsp_stall, rsp_argb_word          | out
//
// Six register stages, stage 1 to stage 6, lie between the two channels:
// a pixel taken into stage 1 passes from stage to stage and shows on rsp_.
// One pixel per cycle is taken while req_stall is low; pixels are independent.
// Each stage holds while the one after it is full and held, so bubbles
// close up and a stall at the output loses and repeats nothing.
// Synchronous active-high reset clears the valid bits only.
module hsv_to_argb_pixel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [hsv2a_pkg::HUE_W-1:0]  req_hue,
   input  logic signed [11:0]                  req_saturation,
   input  logic signed [11:0]                  req_brightness,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_argb_word
);

   localparam int NSTAGE = 6;
   localparam int UW     = hsv2a_pkg::UNIT_W;
   // Half of the channel unit 1024*1024*960
   localparam logic [37:0] HALF_UNIT = 38'(480) << 20;

   function automatic logic [UW-1:0] clamp_unit(input logic signed [11:0] x);
      logic [UW-1:0] r;
      if (x < 0) begin
         r = '0;
      end else if (x > 12'sd1024) begin
         r = UW'(hsv2a_pkg::FX_ONE);
      end else begin
         r = x[UW-1:0];
      end
      return r;
   endfunction

   // Pipeline control: a stage loads when it is empty or its successor loads
   logic [NSTAGE:1] vld_ff, vld_in;
   logic [NSTAGE:1] go;
   hsv2a_pkg::hue_en_type hue_en;

   always_comb begin
      go[NSTAGE] = !vld_ff[NSTAGE] || !rsp_stall;
      for (int i = NSTAGE - 1; i >= 1; i--) begin
         go[i] = !vld_ff[i] || go[i+1];
      end
      vld_in = vld_ff;
      if (go[1]) begin
         vld_in[1] = req_valid;
      end
      for (int i = 2; i <= NSTAGE; i++) begin
         if (go[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
      hue_en.s1 = go[1];
      hue_en.s2 = go[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !go[1];
   assign rsp_valid = vld_ff[NSTAGE];

   // Hue path: sector and distance are ready alongside stage 2
   logic [2:0]                       hue_sector;
   logic [hsv2a_pkg::HUE_FRAC_W-1:0] hue_dist;

   hsv2a_hue_split u_hue (
      .clock  (clock),
      .en     (hue_en),
      .hue    (req_hue),
      .sector (hue_sector),
      .span   (hue_dist)
   );

   // Stage 1: clamp saturation and value to 0..1.0
   logic [UW-1:0] v1_ff, s1_ff;

   // Stage 2: product p = v*s (chroma / 960) and alpha byte
   logic [20:0]   p2_ff;
   logic [UW-1:0] v2_ff;
   logic [7:0]    a2_ff;

   // Stage 3: k = v*1024 - p (offset m / 960), p*t (secondary x)
   logic [20:0]   k3_ff;
   logic [29:0]   pt3_ff;
   logic [2:0]    sect3_ff;
   logic [7:0]    a3_ff;

   // Stage 4: middle channel amount, smallest channel byte
   logic [29:0]   q4_ff;
   logic [7:0]    min4_ff;
   logic [2:0]    sect4_ff;
   logic [7:0]    a4_ff;

   // Stage 5: middle channel scaled by 255, rounded, divided by 2^26
   logic [11:0]   z5_ff;
   logic [7:0]    min5_ff;
   logic [2:0]    sect5_ff;
   logic [7:0]    a5_ff;

   // Stage 6: output word
   logic [31:0]   word6_ff;

   logic [27:0]   mid_prod;
   logic [7:0]    mid6;
   logic [7:0]    red6, green6, blue6;

   // Divide by 15 finishes the division by the channel unit; the largest
   // channel is always the alpha byte, so only the middle one needs it
   always_comb begin
      mid_prod = 28'(z5_ff) * 28'(hsv2a_pkg::RECIP15);
      mid6     = 8'(mid_prod >> hsv2a_pkg::RECIP15_SHIFT);
      unique case (sect5_ff)
         hsv2a_pkg::SECT_RED_YELLOW: begin
            red6 = a5_ff;   green6 = mid6;  blue6 = min5_ff;
         end
         hsv2a_pkg::SECT_YELLOW_GREEN: begin
            red6 = mid6;    green6 = a5_ff; blue6 = min5_ff;
         end
         hsv2a_pkg::SECT_GREEN_CYAN: begin
            red6 = min5_ff; green6 = a5_ff; blue6 = mid6;
         end
         hsv2a_pkg::SECT_CYAN_BLUE: begin
            red6 = min5_ff; green6 = mid6;  blue6 = a5_ff;
         end
         hsv2a_pkg::SECT_BLUE_MAGENTA: begin
            red6 = mid6;    green6 = min5_ff; blue6 = a5_ff;
         end
         hsv2a_pkg::SECT_MAGENTA_RED: begin
            red6 = a5_ff;   green6 = min5_ff; blue6 = mid6;
         end
         default: begin
            red6 = '0;      green6 = '0;    blue6 = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         v1_ff <= clamp_unit(req_brightness);
         s1_ff <= clamp_unit(req_saturation);
      end
      if (go[2]) begin
         p2_ff <= 21'(22'(v1_ff) * 22'(s1_ff));
         v2_ff <= v1_ff;
         a2_ff <= 8'((19'(v1_ff) * 19'd255 + 19'd512) >> hsv2a_pkg::FX_BITS);
      end
      if (go[3]) begin
         k3_ff    <= 21'({v2_ff[UW-2:0], {hsv2a_pkg::FX_BITS{1'b0}}}) - p2_ff
                     + (v2_ff[UW-1] ? 21'(1) << 20 : 21'd0);
         pt3_ff   <= 30'(31'(p2_ff) * 31'(hue_dist));
         sect3_ff <= hue_sector;
         a3_ff    <= a2_ff;
      end
      if (go[4]) begin
         q4_ff    <= 30'(k3_ff) * 30'(hsv2a_pkg::HUE_SECTOR) + pt3_ff;
         min4_ff  <= 8'((29'(k3_ff) * 29'd255 + (29'(1) << 19)) >> 20);
         sect4_ff <= sect3_ff;
         a4_ff    <= a3_ff;
      end
      if (go[5]) begin
         z5_ff    <= 12'((38'(q4_ff) * 38'd255 + HALF_UNIT) >> 26);
         min5_ff  <= min4_ff;
         sect5_ff <= sect4_ff;
         a5_ff    <= a4_ff;
      end
      if (go[6]) begin
         word6_ff <= {a5_ff, red6, green6, blue6};
      end
   end

   assign rsp_argb_word = word6_ff;

   // A transfer always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[1])
      else $error("accepted pixel not captured in stage 1");

   // A held middle stage keeps its pixel and its sector
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && !go[4]) |=> (vld_ff[3] && $stable(sect3_ff) && $stable(k3_ff)))
      else $error("stage 3 lost or changed a held pixel");

   // The brightest channel equals the alpha byte
   a_max_is_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_argb_word[23:16] == rsp_argb_word[31:24] ||
                     rsp_argb_word[15:8]  == rsp_argb_word[31:24] ||
                     rsp_argb_word[7:0]   == rsp_argb_word[31:24]))
      else $error("no colour channel matches alpha");

   // Zero alpha means a black, fully transparent word
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_argb_word[31:24] == 8'd0) |-> (rsp_argb_word == 32'd0))
      else $error("colour present with zero alpha");

endmodule

[verif/tb_hsv_to_argb_pixel.sv]
`timescale 1ns / 100ps

module tb_hsv_to_argb_pixel;

   // One channel unit is 1/(1024*1024*960) of full scale; a full turn of hue
   // is six sectors.
   localparam longint unsigned CHAN_UNIT =
      64'(hsv2a_pkg::FX_ONE) * 64'(hsv2a_pkg::FX_ONE) * 64'(hsv2a_pkg::HUE_SECTOR);
   localparam int HUE_TURN    = 6 * hsv2a_pkg::HUE_SECTOR;
   // Generous bound: every pixel waiting out the longest sender gap and the
   // longest receiver stall, plus the long hold, taken several times over.
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_hue        = '0;
   logic signed [11:0] req_saturation = '0;
   logic signed [11:0] req_brightness = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [31:0]        rsp_argb_word;

   // Words still owed by the block, oldest first
   logic [31:0] expected_words[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   // Idling switches for each side, and the long output hold in cycles
   bit          req_idle  = 1'b0;
   bit          rsp_idle  = 1'b0;
   int          hold_left = 0;

   hsv_to_argb_pixel dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_argb_word  (rsp_argb_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: abandon the run if it never drains
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_words.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Scale a channel amount to a byte, rounding half up
   function automatic logic [7:0] chan_byte(input longint unsigned amount);
      longint unsigned scaled;
      scaled = (amount * 255 + CHAN_UNIT / 2) / CHAN_UNIT;
      if (scaled > 255)
         scaled = 255;
      return scaled[7:0];
   endfunction

   // Expected ARGB word for one HSV pixel
   function automatic logic [31:0] predict_argb(input logic signed [15:0] hue,
                                                input logic signed [11:0] sat,
                                                input logic signed [11:0] bright);
      int              h, s, v, sect, frac, span;
      longint unsigned chroma, second, offset, red, green, blue;
      int unsigned     alpha;
      h = hue;
      s = sat;
      v = bright;
      // Clamp saturation and value into 0..1.0
      if (s < 0) s = 0;
      if (s > hsv2a_pkg::FX_ONE) s = hsv2a_pkg::FX_ONE;
      if (v < 0) v = 0;
      if (v > hsv2a_pkg::FX_ONE) v = hsv2a_pkg::FX_ONE;
      // Floor modulo: negative hues wrap up, full turns wrap down
      h = h % HUE_TURN;
      if (h < 0)
         h += HUE_TURN;
      sect = h / hsv2a_pkg::HUE_SECTOR;
      frac = h % hsv2a_pkg::HUE_SECTOR;
      // Odd sectors run the secondary component downhill
      span = (sect % 2 == 1) ? hsv2a_pkg::HUE_SECTOR - frac : frac;
      chroma = longint'(v) * longint'(s) * hsv2a_pkg::HUE_SECTOR;
      second = longint'(v) * longint'(s) * longint'(span);
      offset = longint'(v) * hsv2a_pkg::FX_ONE * hsv2a_pkg::HUE_SECTOR - chroma;
      red   = 0;
      green = 0;
      blue  = 0;
      case (3'(sect))
         hsv2a_pkg::SECT_RED_YELLOW: begin
            red   = chroma;
            green = second;
         end
         hsv2a_pkg::SECT_YELLOW_GREEN: begin
            red   = second;
            green = chroma;
         end
         hsv2a_pkg::SECT_GREEN_CYAN: begin
            green = chroma;
            blue  = second;
         end
         hsv2a_pkg::SECT_CYAN_BLUE: begin
            green = second;
            blue  = chroma;
         end
         hsv2a_pkg::SECT_BLUE_MAGENTA: begin
            red  = second;
            blue = chroma;
         end
         default: begin
            red  = chroma;
            blue = second;
         end
      endcase
      alpha = (v * 255 + hsv2a_pkg::FX_ONE / 2) / hsv2a_pkg::FX_ONE;
      if (alpha > 255)
         alpha = 255;
      return {alpha[7:0], chan_byte(red + offset), chan_byte(green + offset),
              chan_byte(blue + offset)};
   endfunction

   // Offer one pixel and hold it until the block takes it. On return the
   // caller stands on the edge of the transfer, and valid is still high so
   // that a following pixel may go straight out with no gap.
   task automatic send_pixel(input logic signed [15:0] hue,
                             input logic signed [11:0] sat,
                             input logic signed [11:0] bright);
      int gap;
      gap = req_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bright;
      // Advance until an edge sees valid high and stall low
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      expected_words.push_back(predict_argb(hue, sat, bright));
   endtask

   // Most pixels keep saturation and value inside 0..1.0, where the colour
   // arithmetic does its work; the rest cover the full signed range so that
   // every input bit toggles and clamping gets exercised.
   task automatic send_random_pixel();
      logic signed [15:0] hue;
      logic signed [11:0] sat, bright;
      hue = 16'($urandom());
      if ($urandom_range(0, 3) == 0) begin
         sat    = 12'($urandom());
         bright = 12'($urandom());
      end else begin
         sat    = 12'($urandom_range(0, hsv2a_pkg::FX_ONE));
         bright = 12'($urandom_range(0, hsv2a_pkg::FX_ONE));
      end
      send_pixel(hue, sat, bright);
   endtask

   // Response side: check every transfer against the oldest expectation,
   // then draw how long to stall before the next one. A long hold, when
   // requested, overrides the per-word stall and is counted down here.
   initial begin : response_side
      int          stall_left;
      logic        stall_next;
      logic [31:0] want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_argb_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_argb_word !== want)
                  report_mismatch($sformatf("argb_word %h, expected %h",
                                            rsp_argb_word, want));
            end
            stall_left = rsp_idle ? $urandom_range(0, 14) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Field extremes, every sector, hue wrapping both ways, clamping of
   // saturation and value at both ends, and a black pixel.
   task automatic test_directed();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_pixel(16'sd0,      12'sd1024,  12'sd1024);
      send_pixel(16'sd960,    12'sd1024,  12'sd1024);
      send_pixel(16'sd1920,   12'sd1024,  12'sd1024);
      send_pixel(16'sd2880,   12'sd1024,  12'sd1024);
      send_pixel(16'sd3840,   12'sd1024,  12'sd1024);
      send_pixel(16'sd4800,   12'sd1024,  12'sd1024);
      send_pixel(16'sd5759,   12'sd1024,  12'sd1024);
      send_pixel(16'sd5760,   12'sd800,   12'sd900);
      send_pixel(-16'sd1,     12'sd800,   12'sd900);
      send_pixel(-16'sd32768, 12'sd600,   12'sd1000);
      send_pixel(16'sd32767,  12'sd600,   12'sd1000);
      send_pixel(16'sd480,    12'sd512,   12'sd700);
      send_pixel(16'sd959,    12'sd1000,  12'sd1000);
      send_pixel(16'sd2400,   -12'sd2048, 12'sd1024);
      send_pixel(16'sd2400,   12'sd2047,  12'sd1024);
      send_pixel(16'sd3000,   12'sd1025,  12'sd512);
      send_pixel(16'sd3000,   -12'sd1,    12'sd512);
      send_pixel(16'sd1234,   12'sd1024,  12'sd0);
      send_pixel(16'sd1234,   12'sd700,   -12'sd2048);
      send_pixel(16'sd4000,   12'sd700,   12'sd2047);
      send_pixel(16'sd4000,   12'sd700,   12'sd1025);
      send_pixel(16'sd1234,   12'sd1,     12'sd1);
      send_pixel(16'sd1234,   12'sd0,     12'sd1024);
      send_pixel(-16'sd5760,  12'sd700,   12'sd300);
      send_pixel(16'sd2400,   12'sd1023,  12'sd1023);
   endtask

   // Random pixels with both sides idling at random
   task automatic test_random_idling();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      repeat (1000) send_random_pixel();
   endtask

   // Full rate on both sides: one transfer per cycle
   task automatic test_full_rate();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      repeat (250) send_random_pixel();
   endtask

   // Hold the output for a long stretch while pixels keep coming, so the
   // pipeline fills and pushes back on its input, then releases in order.
   task automatic test_output_hold();
      req_idle  = 1'b0;
      rsp_idle  = 1'b0;
      hold_left = 400;
      repeat (120) send_random_pixel();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_idling();
      test_full_rate();
      test_output_hold();

      // Drop valid, let every owed word arrive, then watch for strays
      req_valid <= 1'b0;
      rsp_idle = 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
